>>> hw/rtl/qsd_pkg.sv
// ----------------------------------------------------------------------------
// qsd_pkg
// Shared types and constants of the quadrature step decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qsd_pkg;

    localparam int unsigned PIN_IDX_W   = 4;
    localparam int unsigned HIST_W      = 8;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned PERIOD_W    = 16;
    localparam int unsigned SPEED_W     = 16;
    localparam int unsigned TALLY_W     = 16;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned CFG_IDX_W   = 1;

    localparam int unsigned SPEED_SCALE = 1000;
    // tally * 1000 fits in tally width plus ceil(log2(1000)) bits
    localparam int unsigned PROD_W      = TALLY_W + $clog2(SPEED_SCALE);
    localparam int unsigned DIV_CNT_W   = $clog2(PROD_W + 1);

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(100);
    localparam logic [SPEED_W-1:0]  SPEED_MAX    = '1;
    localparam logic [TALLY_W-1:0]  TALLY_MAX    = '1;

    // Bit i set when transition index i is a legal quadrature move
    localparam logic [15:0] VALID_MOVE = 16'h6996;

    localparam logic [HIST_W-1:0] CODE_A = 8'h17;
    localparam logic [HIST_W-1:0] CODE_B = 8'h2B;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD   = 1'b0,
        CFG_POLARITY = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV,
        S_STEP
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage : qsd_pkg

`default_nettype wire

>>> hw/rtl/qsd_sample_if.sv
// ----------------------------------------------------------------------------
// qsd_sample_if
// Input channel: one sample of both encoder pins plus millisecond time.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsd_sample_if;
    logic                              valid;
    logic                              ready;
    logic                              clk_level;
    logic                              dt_level;
    logic [qsd_pkg::TIME_W-1:0]        time_ms;

    modport source (output valid, output clk_level, output dt_level, output time_ms,
                    input ready);
    modport sink   (input valid, input clk_level, input dt_level, input time_ms,
                    output ready);
endinterface : qsd_sample_if

`default_nettype wire

>>> hw/rtl/qsd_step_if.sv
// ----------------------------------------------------------------------------
// qsd_step_if
// Output channel: one decoded step with direction and speed.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsd_step_if;
    logic                              valid;
    logic                              ready;
    logic                              direction;
    logic [qsd_pkg::SPEED_W-1:0]       steps_per_second;

    modport source (output valid, output direction, output steps_per_second,
                    input ready);
    modport sink   (input valid, input direction, input steps_per_second,
                    output ready);
endinterface : qsd_step_if

`default_nettype wire

>>> hw/rtl/qsd_div.sv
// ----------------------------------------------------------------------------
// qsd_div
// Restoring divider, one quotient bit per cycle, saturating 16-bit quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module qsd_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [qsd_pkg::PROD_W-1:0]        dividend,
    input  wire logic [qsd_pkg::PERIOD_W-1:0]      divisor,
    output qsd_pkg::div_status_t                   status,
    output logic      [qsd_pkg::SPEED_W-1:0]       quotient
);

    // dividend bits shift out at the top while quotient bits shift in below
    logic [qsd_pkg::PROD_W-1:0]     dvd_reg, dvd_next;
    logic [qsd_pkg::PERIOD_W-1:0]   dsr_reg, dsr_next;
    logic [qsd_pkg::PERIOD_W-1:0]   rem_reg, rem_next;
    logic [qsd_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [qsd_pkg::PERIOD_W:0]     rem_shift;
    logic [qsd_pkg::PERIOD_W:0]     rem_diff;
    logic                           q_bit;

    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[qsd_pkg::PROD_W-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        q_bit     = (rem_shift >= {1'b0, dsr_reg});
    end

    always_comb
    begin
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            cnt_next  = qsd_pkg::DIV_CNT_W'(qsd_pkg::PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[qsd_pkg::PROD_W-2:0], q_bit};
            rem_next = q_bit ? rem_diff[qsd_pkg::PERIOD_W-1:0]
                             : rem_shift[qsd_pkg::PERIOD_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == qsd_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = (|dvd_reg[qsd_pkg::PROD_W-1:qsd_pkg::SPEED_W]) ? qsd_pkg::SPEED_MAX
                                                                  : dvd_reg[qsd_pkg::SPEED_W-1:0];

endmodule : qsd_div

`default_nettype wire

>>> hw/rtl/quadrature_step_decoder_with_speed.sv
// ----------------------------------------------------------------------------
// quadrature_step_decoder_with_speed
// Table-checked quadrature decoder with a periodic steps-per-second estimate.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  samples   in    valid/ready    clk_level, dt_level, time_ms[31:0]
//  steps     out   valid/ready    direction, steps_per_second[15:0]
//  cfg       in    cfg_we         cfg_index (0 period, 1 polarity), cfg_data
//
//  A sample passes the idle, check and step states; a closing nonzero period
//  adds a multiply state and a 26-step restoring divide of tally*1000 by the
//  period, one quotient bit per cycle. A zero period closes with no divide.
//  samples.ready is high only while the sequencer is idle. A step waits in
//  its commit state while an earlier step is still held in the output
//  register. Reset brings the period to 100 ms and all decoder state to zero.
//
`default_nettype none

module quadrature_step_decoder_with_speed (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    qsd_sample_if.sink                               samples,
    qsd_step_if.source                               steps,
    input  wire logic                                cfg_we,
    input  wire logic [qsd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [qsd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    qsd_pkg::state_t                    state_reg, state_next;

    logic [qsd_pkg::PERIOD_W-1:0]       period_reg;
    logic                               polarity_reg;

    logic                               clk_lvl_reg;
    logic                               dt_lvl_reg;
    logic [qsd_pkg::TIME_W-1:0]         time_reg;

    logic [qsd_pkg::PIN_IDX_W-1:0]      tindex_reg;
    logic [qsd_pkg::HIST_W-1:0]         history_reg;
    logic [qsd_pkg::TALLY_W-1:0]        tally_reg;
    logic [qsd_pkg::TIME_W-1:0]         start_reg;
    logic [qsd_pkg::SPEED_W-1:0]        speed_reg;
    logic [qsd_pkg::PROD_W-1:0]         product_reg;

    logic                               out_valid_reg;
    logic                               out_dir_reg;
    logic [qsd_pkg::SPEED_W-1:0]        out_speed_reg;

    logic [qsd_pkg::TIME_W-1:0]         elapsed;
    logic                               period_hit;
    logic                               period_zero;
    logic [qsd_pkg::PIN_IDX_W-1:0]      tindex_new;
    logic [qsd_pkg::HIST_W-1:0]         history_new;
    logic                               move_ok;
    logic [qsd_pkg::HIST_W-1:0]         cw_code;
    logic [qsd_pkg::HIST_W-1:0]         ccw_code;
    logic                               hit_cw;
    logic                               hit_ccw;
    logic                               hit;
    logic                               step_go;
    logic [qsd_pkg::SPEED_W-1:0]        speed_step;

    logic                               accept;
    logic                               div_start;
    logic                               zero_load;
    logic                               div_load;
    logic                               step_commit;

    qsd_pkg::div_status_t               div_status;
    logic [qsd_pkg::SPEED_W-1:0]        div_quot;

    qsd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (period_reg),
        .status   (div_status),
        .quotient (div_quot)
    );

    always_comb
    begin
        elapsed     = time_reg - start_reg;
        period_hit  = (elapsed >= {{(qsd_pkg::TIME_W-qsd_pkg::PERIOD_W){1'b0}}, period_reg});
        period_zero = (period_reg == '0);
        tindex_new  = {tindex_reg[1:0], dt_lvl_reg, clk_lvl_reg};
        history_new = {history_reg[3:0], tindex_new};
        move_ok     = qsd_pkg::VALID_MOVE[tindex_new];
        cw_code     = polarity_reg ? qsd_pkg::CODE_B : qsd_pkg::CODE_A;
        ccw_code    = polarity_reg ? qsd_pkg::CODE_A : qsd_pkg::CODE_B;
        hit_cw      = move_ok && (history_new == cw_code);
        hit_ccw     = move_ok && (history_new == ccw_code);
        hit         = hit_cw || hit_ccw;
        // hold the commit while the previous step still sits in the output
        step_go     = !hit || !out_valid_reg || steps.ready;
        speed_step  = (speed_reg == '0) ? qsd_pkg::SPEED_W'(1) : speed_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qsd_pkg::S_IDLE:
            begin
                if (samples.valid)
                    state_next = qsd_pkg::S_CHECK;
            end
            qsd_pkg::S_CHECK:
            begin
                if (period_hit && !period_zero)
                    state_next = qsd_pkg::S_MUL;
                else
                    state_next = qsd_pkg::S_STEP;
            end
            qsd_pkg::S_MUL:
            begin
                state_next = qsd_pkg::S_DIV;
            end
            qsd_pkg::S_DIV:
            begin
                if (div_status.done)
                    state_next = qsd_pkg::S_STEP;
            end
            qsd_pkg::S_STEP:
            begin
                if (step_go)
                    state_next = qsd_pkg::S_IDLE;
            end
            default:
            begin
                state_next = qsd_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        samples.ready = 1'b0;
        div_start     = 1'b0;
        zero_load     = 1'b0;
        div_load      = 1'b0;
        step_commit   = 1'b0;
        case (state_reg)
            qsd_pkg::S_IDLE:  samples.ready = 1'b1;
            qsd_pkg::S_CHECK: zero_load     = period_hit && period_zero;
            qsd_pkg::S_MUL:   div_start     = 1'b1;
            qsd_pkg::S_DIV:   div_load      = div_status.done;
            qsd_pkg::S_STEP:  step_commit   = step_go;
            default:          samples.ready = 1'b0;
        endcase
    end

    assign accept = samples.valid && samples.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qsd_pkg::S_IDLE;
            period_reg    <= qsd_pkg::PERIOD_RESET;
            polarity_reg  <= 1'b0;
            tindex_reg    <= '0;
            history_reg   <= '0;
            tally_reg     <= '0;
            start_reg     <= '0;
            speed_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_index)
                    qsd_pkg::CFG_PERIOD:   period_reg   <= cfg_data[qsd_pkg::PERIOD_W-1:0];
                    qsd_pkg::CFG_POLARITY: polarity_reg <= cfg_data[0];
                    default:               polarity_reg <= polarity_reg;
                endcase
            end

            if (zero_load)
            begin
                speed_reg <= qsd_pkg::SPEED_MAX;
                tally_reg <= '0;
                start_reg <= time_reg;
            end
            else if (div_load)
            begin
                speed_reg <= div_quot;
                tally_reg <= '0;
                start_reg <= time_reg;
            end
            else if (step_commit)
            begin
                tindex_reg <= tindex_new;
                if (move_ok)
                    history_reg <= history_new;
                if (hit)
                begin
                    if (tally_reg != qsd_pkg::TALLY_MAX)
                        tally_reg <= tally_reg + 1'b1;
                    speed_reg <= speed_step;
                end
            end

            if (step_commit && hit)
                out_valid_reg <= 1'b1;
            else if (steps.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            clk_lvl_reg <= samples.clk_level;
            dt_lvl_reg  <= samples.dt_level;
            time_reg    <= samples.time_ms;
        end
        if (state_reg == qsd_pkg::S_CHECK)
            product_reg <= qsd_pkg::PROD_W'(tally_reg) * qsd_pkg::PROD_W'(qsd_pkg::SPEED_SCALE);
        if (step_commit && hit)
        begin
            out_dir_reg   <= !hit_cw;
            out_speed_reg <= speed_step;
        end
    end

    assign steps.valid            = out_valid_reg;
    assign steps.direction        = out_dir_reg;
    assign steps.steps_per_second = out_speed_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !samples.ready)
        else $error("sample taken while previous sample still in work");

    a_speed_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        steps.valid |-> (steps.steps_per_second != '0))
        else $error("step reported with zero speed");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> (state_reg == qsd_pkg::S_DIV))
        else $error("divider finished outside the divide state");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == qsd_pkg::S_IDLE) |-> !div_status.busy)
        else $error("divider still running while sequencer idle");

    a_div_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (period_reg != '0))
        else $error("divider started with zero period");
`endif

endmodule : quadrature_step_decoder_with_speed

`default_nettype wire

>>> verif/quadrature_step_decoder_with_speed_tb.sv
// ----------------------------------------------------------------------------
// quadrature_step_decoder_with_speed_tb
// Self-checking bench for the quadrature step decoder. Encoder pin samples
// and millisecond times are sent over the sample channel. Each step item is
// checked against a cycle-free predictor of the decoder, speed estimate
// included. Both channels idle at random.
// ----------------------------------------------------------------------------

module quadrature_step_decoder_with_speed_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int CYCLE_LIMIT   = 6_000_000;
    // longest sample runs through the divide; leave margin before config writes
    localparam int DRAIN_CYCLES  = 64;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int SOAK_STEPS    = 20;

    localparam logic [7:0] HIST_FWD = 8'h17;
    localparam logic [7:0] HIST_REV = 8'h2B;

    typedef struct packed {
        logic        direction;
        logic [15:0] steps_per_second;
    } step_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                           cfg_we;
    logic [qsd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [qsd_pkg::CFG_DATA_W-1:0] cfg_data;

    qsd_sample_if samples_ch ();
    qsd_step_if   steps_ch ();

    quadrature_step_decoder_with_speed dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_ch),
        .steps     (steps_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted decoder state and configuration
    logic [3:0]  pr_index;
    logic [7:0]  pr_history;
    logic [15:0] pr_tally;
    logic [31:0] pr_period_start;
    logic [15:0] pr_speed;
    logic [15:0] pr_period_cfg;
    logic        pr_polarity;

    step_rec_t   pending_steps[$];

    int          fail_count  = 0;
    int          cycle_count = 0;
    int          stall_left  = 0;
    bit          src_idle_on  = 1'b1;
    bit          sink_idle_on = 1'b1;
    logic [31:0] ms_clock = 32'd0;
    logic [1:0]  pin_pair = 2'b00;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // a legal quadrature move flips exactly one of the two pins
    function automatic bit is_legal_move(logic [3:0] idx);
        return $countones(idx[3:2] ^ idx[1:0]) == 1;
    endfunction

    task automatic decode_sample(input logic clk_lv, input logic dt_lv,
                                 input logic [31:0] now);
        logic [31:0] elapsed;
        logic [31:0] scaled;
        logic [7:0]  cw_code;
        logic [7:0]  ccw_code;
        step_rec_t   rec;
        elapsed = now - pr_period_start;
        if (elapsed >= 32'(pr_period_cfg)) begin
            if (pr_period_cfg == 16'd0) begin
                pr_speed = 16'hFFFF;
            end else begin
                scaled   = (32'(pr_tally) * 32'd1000) / 32'(pr_period_cfg);
                pr_speed = (scaled > 32'h0000_FFFF) ? 16'hFFFF : scaled[15:0];
            end
            pr_tally        = 16'd0;
            pr_period_start = now;
        end
        pr_index = {pr_index[1:0], dt_lv, clk_lv};
        if (is_legal_move(pr_index)) begin
            pr_history = {pr_history[3:0], pr_index};
            cw_code    = pr_polarity ? HIST_REV : HIST_FWD;
            ccw_code   = pr_polarity ? HIST_FWD : HIST_REV;
            if (pr_history == cw_code || pr_history == ccw_code) begin
                if (pr_tally != 16'hFFFF)
                    pr_tally = pr_tally + 16'd1;
                if (pr_speed == 16'd0)
                    pr_speed = 16'd1;
                rec.direction        = (pr_history == ccw_code);
                rec.steps_per_second = pr_speed;
                pending_steps.push_back(rec);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // pins = {dt, clk}; valid stays high after acceptance until the next item
    task automatic send_sample(input logic [1:0] pins, input logic [31:0] now);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge clk);
            samples_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        samples_ch.valid     <= 1'b1;
        samples_ch.clk_level <= pins[0];
        samples_ch.dt_level  <= pins[1];
        samples_ch.time_ms   <= now;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        decode_sample(pins[0], pins[1], now);
        pin_pair = pins;
        ms_clock = now;
    endtask

    // wait for every step item to arrive and the sequencer to settle
    task automatic quiesce();
        @(negedge clk);
        samples_ch.valid <= 1'b0;
        while (pending_steps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input qsd_pkg::cfg_index_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == qsd_pkg::CFG_PERIOD)
            pr_period_cfg = value;
        else
            pr_polarity = value[0];
    endtask

    task automatic set_config(input logic [15:0] period, input logic polarity);
        logic [15:0] pol_word;
        // upper bits of the polarity word are don't-care
        pol_word = {15'($urandom_range(0, 32767)), polarity};
        quiesce();
        write_reg(qsd_pkg::CFG_PERIOD, period);
        write_reg(qsd_pkg::CFG_POLARITY, pol_word);
    endtask

    // ------------------------------------------------------------------
    // step sink: random back-pressure and checking
    // ------------------------------------------------------------------

    always @(negedge clk) begin
        if (stall_left == 0 && sink_idle_on && $urandom_range(0, 99) < 15)
            stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                    : $urandom_range(8, 40);
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            steps_ch.ready <= 1'b0;
        end else begin
            steps_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        step_rec_t want;
        if (rst_n && steps_ch.valid && steps_ch.ready) begin
            if (pending_steps.size() == 0) begin
                $error("step item with none expected: direction %0d, steps_per_second %0d",
                       steps_ch.direction, steps_ch.steps_per_second);
                fail_count++;
            end else begin
                want = pending_steps.pop_front();
                if (steps_ch.direction !== want.direction) begin
                    $error("direction: expected %0d, got %0d",
                           want.direction, steps_ch.direction);
                    fail_count++;
                end
                if (steps_ch.steps_per_second !== want.steps_per_second) begin
                    $error("steps_per_second: expected %0d, got %0d",
                           want.steps_per_second, steps_ch.steps_per_second);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("quadrature_step_decoder_with_speed regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset config: steps both ways, no-move and double-flip, period boundary
    task automatic test_steps_default();
        send_sample(2'b01, 32'd0);
        send_sample(2'b11, 32'd5);      // first step: speed raised from zero
        send_sample(2'b11, 32'd6);      // pins unchanged
        send_sample(2'b00, 32'd7);      // both pins flip
        send_sample(2'b10, 32'd8);
        send_sample(2'b11, 32'd99);     // counter-clockwise
        send_sample(2'b01, 32'd100);    // elapsed equals the period
        send_sample(2'b00, 32'd101);
        send_sample(2'b01, 32'd102);
        send_sample(2'b11, 32'd103);
    endtask

    // swapped polarity, time wraps through zero
    task automatic test_polarity_wrap();
        set_config(16'd100, 1'b1);
        send_sample(2'b00, 32'hFFFF_FFF0);
        send_sample(2'b01, 32'hFFFF_FFFF);
        send_sample(2'b11, 32'h0000_0005);
        send_sample(2'b10, 32'h0000_0006);
        send_sample(2'b00, 32'h0000_0007);
        send_sample(2'b10, 32'h0000_0008);
        send_sample(2'b11, 32'h0000_0010);
    endtask

    // zero period closes on every sample
    task automatic test_zero_period();
        set_config(16'd0, 1'b0);
        send_sample(2'b00, 32'd20);
        send_sample(2'b01, 32'd20);
        send_sample(2'b11, 32'd20);
    endtask

    task automatic test_max_period();
        set_config(16'hFFFF, 1'b1);
        send_sample(2'b10, 32'd20 + 32'd65534);
        send_sample(2'b00, 32'd20 + 32'd65534);
        send_sample(2'b10, 32'd20 + 32'd65535);
        send_sample(2'b11, 32'd20 + 32'd65535);
    endtask

    function automatic logic [15:0] pick_period();
        case ($urandom_range(0, 19))
            0, 1:    return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'd0;
            4, 5, 6: return 16'($urandom_range(2, 8));
            7, 8, 9, 10, 11: return 16'($urandom_range(10, 200));
            12, 13:  return 16'($urandom_range(200, 5000));
            14, 15:  return 16'($urandom_range(1, 65535));
            default: return 16'd100;
        endcase
    endfunction

    function automatic logic [31:0] time_advance(logic [15:0] period);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 32'($urandom_range(0, 2));
        else if (r < 85)
            return 32'($urandom_range(0, int'(period) / 8 + 1));
        else if (r < 97)
            return 32'($urandom_range(int'(period), 2 * int'(period) + 1));
        else
            return $urandom();
    endfunction

    // one move along the Gray cycle 00-01-11-10
    function automatic logic [1:0] gray_move(logic [1:0] p, bit fwd);
        logic [1:0] b;
        b = {p[1], p[1] ^ p[0]};
        b = fwd ? b + 2'd1 : b - 2'd1;
        return b ^ (b >> 1);
    endfunction

    function automatic logic [1:0] next_pins(logic [1:0] cur, bit fwd);
        int r;
        r = $urandom_range(0, 99);
        if (r < 66)
            return gray_move(cur, fwd);
        else if (r < 78)
            return gray_move(cur, !fwd);
        else if (r < 88)
            return cur;
        else
            return 2'($urandom_range(0, 3));
    endfunction

    // mostly clean rotation with random config, timing and idling per phase
    task automatic test_random_walk();
        int   sent;
        int   phase_len;
        bit   fwd;
        logic [15:0] period;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            period = pick_period();
            set_config(period, 1'($urandom_range(0, 1)));
            src_idle_on  = ($urandom_range(0, 9) < 7);
            sink_idle_on = ($urandom_range(0, 9) < 7);
            fwd          = 1'($urandom_range(0, 1));
            phase_len    = $urandom_range(40, 160);
            if ($urandom_range(0, 3) == 0)
                ms_clock = 32'hFFFF_FFFF - 32'($urandom_range(0, 300));
            repeat (phase_len) begin
                send_sample(next_pins(pin_pair, fwd), ms_clock + time_advance(period));
                if ($urandom_range(0, 99) < 3)
                    fwd = !fwd;
            end
            sent += phase_len;
        end
    endtask

    // a burst of steps at a frozen time in a long period, then close it
    task automatic test_tally_burst();
        logic [31:0] base;
        set_config(16'hFFFF, 1'b0);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        base = ms_clock;
        repeat (SOAK_STEPS) begin
            send_sample(2'b00, base);
            send_sample(2'b01, base);
            send_sample(2'b11, base);
        end
        send_sample(2'b00, base + 32'd65535);
        send_sample(2'b01, base + 32'd65535);
        send_sample(2'b11, base + 32'd65535);
    endtask

    initial begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = qsd_pkg::CFG_PERIOD;
        cfg_data             = '0;
        samples_ch.valid     = 1'b0;
        samples_ch.clk_level = 1'b0;
        samples_ch.dt_level  = 1'b0;
        samples_ch.time_ms   = '0;
        steps_ch.ready       = 1'b0;

        pr_index        = 4'd0;
        pr_history      = 8'd0;
        pr_tally        = 16'd0;
        pr_period_start = 32'd0;
        pr_speed        = 16'd0;
        pr_period_cfg   = 16'd100;
        pr_polarity     = 1'b0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_steps_default();
        test_polarity_wrap();
        test_zero_period();
        test_max_period();
        test_random_walk();
        test_tally_burst();
        quiesce();

        if (fail_count == 0)
            $display("quadrature_step_decoder_with_speed regression: pass");
        else
            $display("quadrature_step_decoder_with_speed regression: fail");
        $finish;
    end

endmodule : quadrature_step_decoder_with_speed_tb
